FILE: rtl/spt_pkg.sv
// Shared types and constants for the stroke peak tracker.
package spt_pkg;

    // Fixed field widths
    localparam int unsigned PEAK_BITS = 16;
    localparam int unsigned TAG_BITS  = 2;
    localparam int unsigned CFG_BITS  = 16;
    localparam int unsigned IDX_BITS  = 2;

    // Register reset values
    localparam logic [CFG_BITS-1:0] TOLERANCE_RESET = 16'd10;
    localparam logic [CFG_BITS-1:0] START_MIN_RESET = 16'hFFFF;
    localparam logic [TAG_BITS-1:0] TAG_RESET       = 2'd0;

    // Sensor codes
    typedef enum logic [TAG_BITS-1:0] {
        TAG_U       = 2'd0,
        TAG_L       = 2'd1,
        TAG_I       = 2'd2,
        TAG_UNKNOWN = 2'd3
    } sensor_tag_t;

    // Configuration register indexes
    typedef enum logic [IDX_BITS-1:0] {
        REG_TOLERANCE = 2'd0,
        REG_START_MIN = 2'd1,
        REG_SENSOR    = 2'd2,
        REG_NONE      = 2'd3
    } cfg_index_t;

endpackage

FILE: rtl/spt_sample_if.sv
// Handshake channels for distance samples and peak results.
interface spt_sample_if #(
    parameter int unsigned DISTANCE_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic [DISTANCE_BITS-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

interface spt_peak_if;
    logic                          valid;
    logic                          ready;
    logic [spt_pkg::PEAK_BITS-1:0] peak_value;
    logic [spt_pkg::TAG_BITS-1:0]  sensor_code;

    modport source (output valid, output peak_value, output sensor_code, input ready);
    modport sink   (input valid, input peak_value, input sensor_code, output ready);
endinterface

FILE: rtl/stroke_peak_tracker_unit.sv
// Stroke peak tracker: running minimum, shape tracker and windowed peak output.
//
//  channel   | dir | beat payload                       | handshake
//  ----------+-----+------------------------------------+-----------------
//  samples   | in  | distance                           | valid / ready
//  peaks     | out | peak_value, sensor_code            | valid / ready
//  cfg       | in  | cfg_index, cfg_data                | cfg_we, no wait
//
//  One sample beat per cycle unless a stall on peaks backs up. A beat lands
//  in an input register, the minimum / shape / window update runs on it once
//  it can advance, and a finished window's peak goes to the output register.
//  The input register frees whenever the output register is empty or taken,
//  so a stall on peaks only backs up once both registers are full.
//  Reset clears the window, loads the minimum with start_minimum's default.
module stroke_peak_tracker_unit #(
    parameter int unsigned HITS_PER_WINDOW = 5,
    parameter int unsigned DISTANCE_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    spt_sample_if.sink                   samples,
    spt_peak_if.source                   peaks,
    input  logic                         cfg_we,
    input  logic [spt_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [spt_pkg::CFG_BITS-1:0] cfg_data
);
    import spt_pkg::*;

    localparam int unsigned WORK_BITS =
        (DISTANCE_BITS > PEAK_BITS) ? DISTANCE_BITS : PEAK_BITS;
    localparam int unsigned HIT_BITS  = $clog2(HITS_PER_WINDOW + 1);

    typedef enum logic [1:0] {
        SH_FLAT_TOP    = 2'd0,
        SH_FLAT_BOTTOM = 2'd1,
        SH_UP          = 2'd2,
        SH_DOWN        = 2'd3
    } shape_t;

    // Configuration registers; start_minimum lands directly in min_reg
    logic [CFG_BITS-1:0]      tol_reg;
    logic [TAG_BITS-1:0]      tag_reg;

    // Input stage
    logic                     in_valid_reg;
    logic [DISTANCE_BITS-1:0] dist_reg;

    // Tracker state
    logic [WORK_BITS-1:0]     min_reg,       min_next;
    logic [HIT_BITS-1:0]      hits_reg,      hits_next;
    shape_t                   shape_reg,     shape_next;
    logic [WORK_BITS-1:0]     prev_reg,      prev_next;
    logic                     have_prev_reg, have_prev_next;
    logic [WORK_BITS-1:0]     best_reg,      best_next;
    logic                     best_valid_reg, best_valid_next;

    // Output stage
    logic                     out_valid_reg, out_valid_next;
    logic [PEAK_BITS-1:0]     peak_reg,      peak_next;
    logic [TAG_BITS-1:0]      code_reg,      code_next;

    logic                     advance;
    logic                     take_in;
    logic [WORK_BITS-1:0]     d_w;
    logic [WORK_BITS-1:0]     diff;
    logic                     hit;
    logic                     feed;
    logic [HIT_BITS-1:0]      hits_inc;
    logic                     close_win;
    logic                     emit;
    shape_t                   shape_step;
    logic                     turn;
    logic [WORK_BITS-1:0]     best_upd;
    logic                     best_valid_upd;

    // Process the held sample once the output slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || peaks.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign take_in = samples.valid && samples.ready;

    assign peaks.valid       = out_valid_reg;
    assign peaks.peak_value  = peak_reg;
    assign peaks.sensor_code = code_reg;

    always_comb
    begin
        d_w      = WORK_BITS'(dist_reg);
        diff     = (d_w >= min_reg) ? (d_w - min_reg) : (min_reg - d_w);
        hit      = (diff <= WORK_BITS'(tol_reg));
        hits_inc = hits_reg + HIT_BITS'(hit);
        // A sample feeds the shape tracker only if it sits above the minimum
        feed     = (d_w > min_reg);

        // Shape step: compare the previous sample against the current one
        shape_step = shape_reg;
        turn       = 1'b0;
        case (shape_reg)
            SH_FLAT_TOP:
            begin
                if (prev_reg < d_w)
                    shape_step = SH_DOWN;
            end
            SH_FLAT_BOTTOM:
            begin
                if (prev_reg > d_w)
                    shape_step = SH_UP;
            end
            SH_UP:
            begin
                if (prev_reg <= d_w)
                    shape_step = (prev_reg == d_w) ? SH_FLAT_TOP : SH_DOWN;
            end
            SH_DOWN:
            begin
                if (prev_reg >= d_w)
                begin
                    turn       = 1'b1;
                    shape_step = (prev_reg == d_w) ? SH_FLAT_BOTTOM : SH_UP;
                end
            end
            default:
            begin
                shape_step = SH_FLAT_TOP;
            end
        endcase

        // Keep the largest turning point of the window
        best_upd       = best_reg;
        best_valid_upd = best_valid_reg;
        if (feed && have_prev_reg && turn && (!best_valid_reg || prev_reg > best_reg))
        begin
            best_upd       = prev_reg;
            best_valid_upd = 1'b1;
        end

        close_win = (hits_inc >= HIT_BITS'(HITS_PER_WINDOW));
        emit      = close_win && best_valid_upd && (tag_reg != TAG_UNKNOWN);

        // Defaults: hold
        min_next        = min_reg;
        hits_next       = hits_reg;
        shape_next      = shape_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        out_valid_next  = out_valid_reg && !peaks.ready;
        peak_next       = peak_reg;
        code_next       = code_reg;

        if (cfg_we && cfg_index == REG_START_MIN)
        begin
            min_next = WORK_BITS'(cfg_data);
        end
        else if (advance)
        begin
            if (d_w < min_reg)
                min_next = d_w;
            if (feed)
            begin
                prev_next      = d_w;
                have_prev_next = 1'b1;
                if (have_prev_reg)
                    shape_next = shape_step;
            end
            best_next       = best_upd;
            best_valid_next = best_valid_upd;
            hits_next       = hits_inc;

            if (close_win)
            begin
                // Drop the window contents; the minimum carries over
                hits_next       = '0;
                have_prev_next  = 1'b0;
                shape_next      = SH_FLAT_TOP;
                best_next       = '0;
                best_valid_next = 1'b0;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                peak_next      = best_upd[PEAK_BITS-1:0];
                code_next      = tag_reg;
            end
        end
    end

    // Control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg        <= TOLERANCE_RESET;
            tag_reg        <= TAG_RESET;
            in_valid_reg   <= 1'b0;
            min_reg        <= WORK_BITS'(START_MIN_RESET);
            hits_reg       <= '0;
            shape_reg      <= SH_FLAT_TOP;
            have_prev_reg  <= 1'b0;
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOLERANCE: tol_reg       <= cfg_data;
                    REG_SENSOR:    tag_reg       <= cfg_data[TAG_BITS-1:0];
                    default:       ;
                endcase
            end
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            min_reg        <= min_next;
            hits_reg       <= hits_next;
            shape_reg      <= shape_next;
            have_prev_reg  <= have_prev_next;
            best_reg       <= best_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
            dist_reg <= samples.distance;
        prev_reg <= prev_next;
        peak_reg <= peak_next;
        code_reg <= code_next;
    end

`ifndef SYNTH
    // The hit count never reaches the window length between beats
    assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg < HIT_BITS'(HITS_PER_WINDOW))
        else $error("hit count escaped window");

    // An unknown sensor never produces a peak beat
    assert property (@(posedge clk) disable iff (!rst_n)
        peaks.valid |-> (peaks.sensor_code != TAG_UNKNOWN))
        else $error("peak emitted for unknown sensor");

    // Without a recorded turn the best value stays cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        !best_valid_reg |-> (best_reg == '0))
        else $error("stale best value");

    // The shape tracker only leaves its rest state once a sample is stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (shape_reg != SH_FLAT_TOP) |-> have_prev_reg)
        else $error("shape moved without previous sample");

    // The minimum only rises through a start_minimum write
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> (min_reg <= $past(min_reg)))
        else $error("running minimum increased");
`endif

endmodule
